// ===== hw/rtl/signed_int_to_decimal_ascii_top_defines.svh =====
// Assertion macros shared by the RTL of the signed integer to decimal text converter.
// Needs signals named clock and reset in the module that uses them.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SINT2DEC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SINT2DEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sint2dec_pkg.sv =====
// Package for the signed integer to decimal text converter.
// Holds the default width, the character codes and elaboration helpers; depends on nothing.
package sint2dec_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int DABBLE_BITS    = 8;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Number of decimal digits in the largest magnitude, 2^(bits-1).
   function automatic int digit_count(input int bits);
      longint unsigned p;
      int n;
      p = 64'd1 << (bits - 1);
      n = 0;
      while (p != 64'd0) begin
         p = p / 64'd10;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii_top.sv =====
// Signed integer to decimal text converter, top level.
// Depends on sint2dec_pkg and signed_int_to_decimal_ascii_top_defines.svh.
//
// Each accepted word on the req_ channel is a two's complement integer; the rsp_ channel
// returns its decimal text one ASCII character per word, most significant digit first,
// with a leading '-' for negative values and rsp_tlast on the final character. Zero gives
// a single '0' and the most negative value is converted without overflow. A number gives
// one character per output word, so 1 to 11 characters at 32 bits (the digit count plus one
// if negative); the result port sends one character per cycle while rsp_tready is high. Conversion runs
// in a pipeline of ceil(VALUE_BITS/8) + 3 stages (seven at 32 bits): a magnitude stage,
// shift-and-add-three stages of eight bits each, a digit count stage and an alignment
// stage, so following numbers are converted while earlier text is still being sent.
`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_BITS = sint2dec_pkg::VALUE_BITS_DEF,
   localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // value (VALUE_BITS, signed), zero padded
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // ascii_char (8)
   output logic               rsp_tlast
);
   import sint2dec_pkg::*;

   localparam int ND    = digit_count(VALUE_BITS);
   localparam int BCD_W = ND * 4;
   localparam int CNT_W = $clog2(ND + 1);
   localparam int SH_W  = $clog2(ND);
   localparam int NSTG  = (VALUE_BITS + DABBLE_BITS - 1) / DABBLE_BITS;
   localparam int P     = NSTG + 3;
   localparam int LZ    = NSTG + 1;
   localparam int AL    = NSTG + 2;

   // Stage control.
   logic         valid_ff [P];
   logic         valid_in [P];
   logic         take [P+1];
   logic         ser_take;
   logic         ser_load;

   // Magnitude stage.
   logic [VALUE_BITS-1:0] mag_ff;
   logic [VALUE_BITS-1:0] mag_in;
   logic                  mneg_ff;
   logic                  mneg_in;
   logic [VALUE_BITS-1:0] raw;

   // Shift-and-add-three stages.
   logic [BCD_W-1:0]      dab_bcd_ff [NSTG];
   logic [BCD_W-1:0]      dab_bcd_in [NSTG];
   logic [VALUE_BITS-1:0] dab_bin_ff [NSTG];
   logic [VALUE_BITS-1:0] dab_bin_in [NSTG];
   logic                  dab_neg_ff [NSTG];
   logic                  dab_neg_in [NSTG];

   // Digit count stage.
   logic [BCD_W-1:0] lz_bcd_ff;
   logic [BCD_W-1:0] lz_bcd_in;
   logic [CNT_W-1:0] lz_nd_ff;
   logic [CNT_W-1:0] lz_nd_in;
   logic [CNT_W-1:0] nd_calc;
   logic             lz_neg_ff;
   logic             lz_neg_in;

   // Alignment stage.
   logic [BCD_W-1:0] al_dig_ff;
   logic [BCD_W-1:0] al_dig_in;
   logic [CNT_W-1:0] al_nd_ff;
   logic [CNT_W-1:0] al_nd_in;
   logic             al_neg_ff;
   logic             al_neg_in;
   logic [SH_W-1:0]  shift_amt;

   // Character serialiser.
   logic             busy_ff;
   logic             busy_in;
   logic             sign_ff;
   logic             sign_in;
   logic [BCD_W-1:0] dig_ff;
   logic [BCD_W-1:0] dig_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [3:0]       top_digit;
   logic             rsp_fire;

   // A stage takes a new word when it is empty or its contents move on.
   always_comb begin
      take[P] = ser_take;
      for (int i = P - 1; i >= 0; i--) begin
         take[i] = !valid_ff[i] || take[i+1];
      end
      for (int i = 0; i < P; i++) begin
         if (take[i]) begin
            valid_in[i] = (i == 0) ? req_tvalid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   assign req_tready = take[0];

   always_ff @(posedge clock) begin
      for (int i = 0; i < P; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   // Magnitude in VALUE_BITS unsigned bits, exact for the most negative value.
   assign raw     = req_tdata[VALUE_BITS-1:0];
   assign mneg_in = take[0] ? raw[VALUE_BITS-1] : mneg_ff;
   assign mag_in  = take[0] ? (raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw) : mag_ff;

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      mneg_ff <= mneg_in;
   end

   for (genvar s = 0; s < NSTG; s++) begin : g_dab
      logic [BCD_W-1:0]      src_bcd;
      logic [VALUE_BITS-1:0] src_bin;
      logic                  src_neg;
      logic [BCD_W-1:0]      b_w;
      logic [VALUE_BITS-1:0] m_w;

      if (s == 0) begin : g_first
         assign src_bcd = '0;
         assign src_bin = mag_ff;
         assign src_neg = mneg_ff;
      end else begin : g_next
         assign src_bcd = dab_bcd_ff[s-1];
         assign src_bin = dab_bin_ff[s-1];
         assign src_neg = dab_neg_ff[s-1];
      end

      always_comb begin
         b_w = src_bcd;
         m_w = src_bin;
         for (int j = 0; j < DABBLE_BITS; j++) begin
            if (s * DABBLE_BITS + j < VALUE_BITS) begin
               for (int d = 0; d < ND; d++) begin
                  if (b_w[4*d +: 4] >= 4'd5) begin
                     b_w[4*d +: 4] = b_w[4*d +: 4] + 4'd3;
                  end
               end
               b_w = {b_w[BCD_W-2:0], m_w[VALUE_BITS-1]};
               m_w = {m_w[VALUE_BITS-2:0], 1'b0};
            end
         end
      end

      assign dab_bcd_in[s] = take[s+1] ? b_w : dab_bcd_ff[s];
      assign dab_bin_in[s] = take[s+1] ? m_w : dab_bin_ff[s];
      assign dab_neg_in[s] = take[s+1] ? src_neg : dab_neg_ff[s];

      always_ff @(posedge clock) begin
         dab_bcd_ff[s] <= dab_bcd_in[s];
         dab_bin_ff[s] <= dab_bin_in[s];
         dab_neg_ff[s] <= dab_neg_in[s];
      end
   end

   // Significant digit count; zero still shows one digit.
   always_comb begin
      nd_calc = CNT_W'(1);
      for (int d = 0; d < ND; d++) begin
         if (dab_bcd_ff[NSTG-1][4*d +: 4] != 4'd0) begin
            nd_calc = CNT_W'(d + 1);
         end
      end
   end

   assign lz_bcd_in = take[LZ] ? dab_bcd_ff[NSTG-1] : lz_bcd_ff;
   assign lz_neg_in = take[LZ] ? dab_neg_ff[NSTG-1] : lz_neg_ff;
   assign lz_nd_in  = take[LZ] ? nd_calc : lz_nd_ff;

   always_ff @(posedge clock) begin
      lz_bcd_ff <= lz_bcd_in;
      lz_neg_ff <= lz_neg_in;
      lz_nd_ff  <= lz_nd_in;
   end

   // Move the leading significant digit to the top of the word.
   assign shift_amt = SH_W'(CNT_W'(ND) - lz_nd_ff);
   assign al_dig_in = take[AL] ? (lz_bcd_ff << {shift_amt, 2'b00}) : al_dig_ff;
   assign al_neg_in = take[AL] ? lz_neg_ff : al_neg_ff;
   assign al_nd_in  = take[AL] ? lz_nd_ff : al_nd_ff;

   always_ff @(posedge clock) begin
      al_dig_ff <= al_dig_in;
      al_neg_ff <= al_neg_in;
      al_nd_ff  <= al_nd_in;
   end

   // The serialiser sends the sign, then one digit per word from the top.
   assign top_digit  = dig_ff[BCD_W-1 -: 4];
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = sign_ff ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, top_digit});
   assign rsp_tlast  = !sign_ff && (cnt_ff == CNT_W'(1));
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign ser_take   = !busy_ff || (rsp_tready && rsp_tlast);
   assign ser_load   = ser_take && valid_ff[AL];

   always_comb begin
      busy_in = busy_ff;
      sign_in = sign_ff;
      dig_in  = dig_ff;
      cnt_in  = cnt_ff;
      if (ser_load) begin
         busy_in = 1'b1;
         sign_in = al_neg_ff;
         dig_in  = al_dig_ff;
         cnt_in  = al_nd_ff;
      end else if (rsp_fire) begin
         if (rsp_tlast) begin
            busy_in = 1'b0;
         end else if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            dig_in = {dig_ff[BCD_W-5:0], 4'b0000};
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sign_ff <= sign_in;
      dig_ff  <= dig_in;
      cnt_ff  <= cnt_in;
   end

   `SINT2DEC_ASSERT_NOW(a_cnt_range, busy_ff, (cnt_ff != '0) && (cnt_ff <= CNT_W'(ND)), "digit count out of range")
   `SINT2DEC_ASSERT_NOW(a_digit_bcd, busy_ff && !sign_ff, top_digit <= 4'd9, "digit is not decimal")
   `SINT2DEC_ASSERT_NOW(a_sign_not_last, busy_ff && sign_ff, !rsp_tlast, "minus sign flagged as last")
   `SINT2DEC_ASSERT_NEXT(a_no_lead_zero, ser_load, (cnt_ff == CNT_W'(1)) || (top_digit != 4'd0), "leading zero loaded")

endmodule
